FILE: rtl/arp_pkg.sv
`default_nettype none

package arp_pkg;

  localparam int ENTRIES_DEF = 32;

  localparam int FUNC_W  = 2;
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int AGE_W   = 8;
  localparam int SLOT_W  = 5;
  localparam int EXP_W   = 6;
  localparam int LFSR_W  = 16;
  localparam int WORD_W  = IP_W + MAC_W + AGE_W;

  localparam logic [LFSR_W-1:0] LFSR_SEED   = 16'hACE1;
  localparam logic [AGE_W-1:0]  AGE_MAX     = 8'hFF;
  localparam logic [AGE_W-1:0]  TIMEOUT_RST = 8'd15;

  localparam int CFG_DW = 32;
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] ADDR_TIMEOUT = 2'd0;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOOKUP = 2'd0,
    FN_INSERT = 2'd1,
    FN_TICK   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MOD,
    ST_WRITE,
    ST_DONE
  } state_t;

  // x^16+x^14+x^13+x^11+1, Fibonacci form, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/arp_in_if.sv
`default_nettype none

interface arp_in_if;
  logic                         valid;
  logic                         ready;
  logic [arp_pkg::FUNC_W-1:0]   func;
  logic [arp_pkg::IP_W-1:0]     ip_addr;
  logic [arp_pkg::MAC_W-1:0]    mac_addr;

  modport source (output valid, func, ip_addr, mac_addr, input ready);
  modport sink   (input valid, func, ip_addr, mac_addr, output ready);
endinterface

`default_nettype wire

FILE: rtl/arp_out_if.sv
`default_nettype none

interface arp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [arp_pkg::MAC_W-1:0]    mac_out;
  logic [arp_pkg::SLOT_W-1:0]   slot_index;
  logic [arp_pkg::EXP_W-1:0]    expired_count;

  modport source (output valid, hit, mac_out, slot_index, expired_count, input ready);
  modport sink   (input valid, hit, mac_out, slot_index, expired_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/arp_ram.sv
`default_nettype none

module arp_ram #(
  parameter int WIDTH = arp_pkg::WORD_W,
  parameter int DEPTH = arp_pkg::ENTRIES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/arp_cache_table_with_aging.sv
`default_nettype none

// ARP cache: ENTRIES slots mapping IPv4 addresses to MAC addresses, with aging.
// in_ch carries one item per valid/ready handshake: func (lookup, insert or
// one-second tick), ip_addr and mac_addr. out_ch returns exactly one result
// per item: hit, mac_out, slot_index and expired_count.
// Every lookup, insert or tick walks the whole entry RAM through one read port,
// one slot per cycle, and a single compare unit inspects each slot as it comes back.
// States each item passes through after it is accepted:
//   lookup miss, tick    SCAN, DECIDE, DONE
//   lookup hit, insert   SCAN, DECIDE, WRITE, DONE
//   insert that evicts   SCAN, DECIDE, MOD, WRITE, DONE  (one reciprocal remainder step)
//   unused function code DONE
// A result turns valid in the same cycle as in_ch.ready returns.
// The block takes one item at a time; in_ch.ready is high only while idle.
// A finished result sits in the output register; the next item may be
// accepted while it waits, and a stalled receiver holds the block only once
// the following result is ready to be loaded.
// Reset (rst_n low, synchronous) empties the table, seeds the victim LFSR
// with 0xACE1 and sets entry_timeout to 15. Slots never written read as IP 0.
// entry_timeout lives at APB address 0; pready is always high.

module arp_cache_table_with_aging #(
  parameter int ENTRIES = arp_pkg::ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  arp_in_if.sink                           in_ch,
  arp_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [arp_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [arp_pkg::CFG_DW-1:0]  pwdata,
  output logic      [arp_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready
);

  localparam int IdxW  = $clog2(ENTRIES);
  localparam int CntW  = $clog2(ENTRIES + 1);
  localparam int IpW   = arp_pkg::IP_W;
  localparam int MacW  = arp_pkg::MAC_W;
  localparam int AgeW  = arp_pkg::AGE_W;
  localparam int WordW = arp_pkg::WORD_W;
  localparam int LfsrW = arp_pkg::LFSR_W;
  localparam int SlotW = arp_pkg::SLOT_W;
  localparam int ExpW  = arp_pkg::EXP_W;
  localparam int CfgDW = arp_pkg::CFG_DW;

  // Reciprocal of ENTRIES, exact for every 16-bit LFSR value
  localparam int RecipSh = LfsrW + $clog2(ENTRIES);
  localparam int RecipM  = ((1 << RecipSh) + ENTRIES - 1) / ENTRIES;
  localparam int ProdW   = RecipSh + LfsrW;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  arp_pkg::state_t state_r, state_nxt;

  logic [arp_pkg::FUNC_W-1:0] op_func_r;
  logic [IpW-1:0]             op_ip_r;
  logic [MacW-1:0]            op_mac_r;

  logic [CntW-1:0]    rd_cnt_r;      // next slot to read
  logic               cmp_vld_r;     // RAM data for cmp_idx_r is present
  logic [IdxW-1:0]    cmp_idx_r;

  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] written_r;     // slot holds stored data, else reads as zero

  logic               found_r;
  logic               free_found_r;
  logic [IdxW-1:0]    slot_r;
  logic [IdxW-1:0]    free_slot_r;
  logic [MacW-1:0]    mac_r;
  logic [CntW-1:0]    exp_cnt_r;

  logic [LfsrW-1:0]   lfsr_r;
  logic [LfsrW-1:0]   quo_r;

  logic [AgeW-1:0]    timeout_r;

  logic               out_valid_r;
  logic               out_hit_r;
  logic [MacW-1:0]    out_mac_r;
  logic [SlotW-1:0]   out_slot_r;
  logic [ExpW-1:0]    out_exp_r;

  // ---------------------------------------------------------------------------
  // Entry RAM: {ip, mac, age} per slot
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [WordW-1:0]  ram_wdata;
  logic [WordW-1:0]  ram_rdata;

  arp_ram #(
    .WIDTH (WordW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_cnt_r[IdxW-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Compare unit: inspect the slot that just came out of the RAM
  // ---------------------------------------------------------------------------
  logic            ent_written;
  logic            ent_valid;
  logic [IpW-1:0]  ent_ip;
  logic [MacW-1:0] ent_mac;
  logic [AgeW-1:0] ent_age;
  logic [AgeW-1:0] age_inc;
  logic            ip_eq;
  logic            age_exp;
  logic            scan_last;
  logic            is_lookup;
  logic            is_insert;
  logic            is_tick;

  assign ent_written = written_r[cmp_idx_r];
  assign ent_valid   = valid_r[cmp_idx_r];
  assign ent_ip      = ent_written ? ram_rdata[WordW-1 -: IpW] : '0;
  assign ent_mac     = ent_written ? ram_rdata[AgeW +: MacW] : '0;
  assign ent_age     = ent_written ? ram_rdata[AgeW-1:0] : '0;
  // saturate at 255
  assign age_inc     = (ent_age == arp_pkg::AGE_MAX) ? ent_age : ent_age + AgeW'(1);
  assign ip_eq       = (ent_ip == op_ip_r);
  assign age_exp     = (age_inc > timeout_r);
  assign scan_last   = cmp_vld_r && (cmp_idx_r == IdxW'(ENTRIES - 1));

  assign is_lookup = (op_func_r == arp_pkg::FN_LOOKUP);
  assign is_insert = (op_func_r == arp_pkg::FN_INSERT);
  assign is_tick   = (op_func_r == arp_pkg::FN_TICK);

  // Victim slot: quotient by reciprocal multiply, then subtract quotient * ENTRIES
  logic [ProdW-1:0] recip_prod;
  logic [LfsrW-1:0] mod_prod;
  logic [LfsrW-1:0] rem_nxt;

  assign recip_prod = ProdW'(lfsr_r) * ProdW'(RecipM);
  assign mod_prod   = quo_r * LfsrW'(ENTRIES);
  assign rem_nxt    = lfsr_r - mod_prod;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  logic in_acc;
  logic res_load;

  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.func inside {arp_pkg::FN_LOOKUP, arp_pkg::FN_INSERT,
                                 arp_pkg::FN_TICK}) begin
            state_nxt = arp_pkg::ST_SCAN;
          end else begin
            state_nxt = arp_pkg::ST_DONE;
          end
        end
      end
      arp_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = arp_pkg::ST_DECIDE;
        end
      end
      arp_pkg::ST_DECIDE: begin
        if (is_lookup) begin
          state_nxt = found_r ? arp_pkg::ST_WRITE : arp_pkg::ST_DONE;
        end else if (is_insert) begin
          state_nxt = (found_r || free_found_r) ? arp_pkg::ST_WRITE : arp_pkg::ST_MOD;
        end else begin
          state_nxt = arp_pkg::ST_DONE;
        end
      end
      arp_pkg::ST_MOD: begin
        state_nxt = arp_pkg::ST_WRITE;
      end
      arp_pkg::ST_WRITE: begin
        state_nxt = arp_pkg::ST_DONE;
      end
      arp_pkg::ST_DONE: begin
        if (res_load) begin
          state_nxt = arp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = arp_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmp_idx_r;
    ram_wdata = {ent_ip, ent_mac, age_inc};
    res_load  = 1'b0;
    case (state_r)
      arp_pkg::ST_SCAN: begin
        // on a tick, age each valid slot in place as it streams past
        ram_we = cmp_vld_r && is_tick && ent_valid;
      end
      arp_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = slot_r;
        ram_wdata = {op_ip_r, (is_lookup ? mac_r : op_mac_r), AgeW'(0)};
      end
      arp_pkg::ST_DONE: begin
        res_load = !out_valid_r || out_ch.ready;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  logic cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready && (paddr == arp_pkg::ADDR_TIMEOUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arp_pkg::ST_IDLE;
      valid_r     <= '0;
      written_r   <= '0;
      lfsr_r      <= arp_pkg::LFSR_SEED;
      timeout_r   <= arp_pkg::TIMEOUT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        timeout_r <= pwdata[AgeW-1:0];
      end

      // drop slots whose age passed the timeout
      if (state_r == arp_pkg::ST_SCAN && cmp_vld_r && is_tick && ent_valid && age_exp) begin
        valid_r[cmp_idx_r] <= 1'b0;
      end

      if (state_r == arp_pkg::ST_WRITE && is_insert) begin
        valid_r[slot_r]   <= 1'b1;
        written_r[slot_r] <= 1'b1;
      end

      // advance the LFSR only when it picked the victim
      if (state_r == arp_pkg::ST_MOD) begin
        lfsr_r <= arp_pkg::lfsr_next(lfsr_r);
      end

      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      arp_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_func_r    <= in_ch.func;
          op_ip_r      <= in_ch.ip_addr;
          op_mac_r     <= in_ch.mac_addr;
          rd_cnt_r     <= '0;
          cmp_vld_r    <= 1'b0;
          cmp_idx_r    <= '0;
          found_r      <= 1'b0;
          free_found_r <= 1'b0;
          slot_r       <= '0;
          free_slot_r  <= '0;
          mac_r        <= '0;
          exp_cnt_r    <= '0;
        end
      end
      arp_pkg::ST_SCAN: begin
        // issue reads ahead, compare each slot in the cycle after its read
        if (rd_cnt_r < CntW'(ENTRIES)) begin
          rd_cnt_r  <= rd_cnt_r + CntW'(1);
          cmp_vld_r <= 1'b1;
          cmp_idx_r <= rd_cnt_r[IdxW-1:0];
        end else begin
          cmp_vld_r <= 1'b0;
        end
        if (cmp_vld_r) begin
          if (is_lookup && ent_valid && ip_eq && !found_r) begin
            found_r <= 1'b1;
            slot_r  <= cmp_idx_r;
            mac_r   <= ent_mac;
          end
          if (is_insert && ip_eq && !found_r) begin
            found_r <= 1'b1;
            slot_r  <= cmp_idx_r;
          end
          if (is_insert && !ent_valid && !free_found_r) begin
            free_found_r <= 1'b1;
            free_slot_r  <= cmp_idx_r;
          end
          if (is_tick && ent_valid && age_exp) begin
            exp_cnt_r <= exp_cnt_r + CntW'(1);
          end
        end
      end
      arp_pkg::ST_DECIDE: begin
        if (is_insert && !found_r) begin
          slot_r <= free_slot_r;
        end
        quo_r <= recip_prod[RecipSh +: LfsrW];
      end
      arp_pkg::ST_MOD: begin
        slot_r <= rem_nxt[IdxW-1:0];
      end
      default: begin
        quo_r <= quo_r;
      end
    endcase

    if (res_load) begin
      out_hit_r  <= is_lookup && found_r;
      out_mac_r  <= (is_lookup && found_r) ? mac_r : '0;
      out_slot_r <= ((is_lookup && found_r) || is_insert) ? SlotW'(slot_r) : '0;
      out_exp_r  <= is_tick ? ExpW'(exp_cnt_r) : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign in_ch.ready          = (state_r == arp_pkg::ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.mac_out       = out_mac_r;
  assign out_ch.slot_index    = out_slot_r;
  assign out_ch.expired_count = out_exp_r;

  assign pready = 1'b1;
  assign prdata = (paddr == arp_pkg::ADDR_TIMEOUT) ? CfgDW'(timeout_r) : '0;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("block took an item while still working on one");

  a_load_into_free_reg: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_ch.ready))
    else $error("result loaded over one not yet taken");

  a_valid_implies_written: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r & ~written_r) == '0)
    else $error("valid slot never written");

  a_hit_not_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.hit) |-> (out_ch.expired_count == '0))
    else $error("result reports both a hit and expired entries");

endmodule

`default_nettype wire

FILE: verif/arp_cache_checker.sv
`timescale 1ns / 100ps

module arp_cache_checker
  import arp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  arp_in_if                 in_ch,
  arp_out_if                out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                fault_total,
  output int                open_items
);

  localparam int N_SLOTS = ENTRIES_DEF;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac;
    logic [SLOT_W-1:0] slot;
    logic [EXP_W-1:0] expired;
  } arp_reply_t;

  // Shadow copy of the table, the victim sequence and the timeout register.
  logic              slot_valid [N_SLOTS];
  logic [IP_W-1:0]   slot_ip    [N_SLOTS];
  logic [MAC_W-1:0]  slot_mac   [N_SLOTS];
  logic [AGE_W-1:0]  slot_age   [N_SLOTS];
  logic [LFSR_W-1:0] victim_seq;
  logic [AGE_W-1:0]  age_limit;

  arp_reply_t awaited_replies [$];
  arp_reply_t want;
  arp_reply_t got;
  int         idx;

  function automatic arp_reply_t resolve_arp_item(input logic [FUNC_W-1:0] fn,
                                                  input logic [IP_W-1:0]   ip,
                                                  input logic [MAC_W-1:0]  mac);
    arp_reply_t r;
    int         pick;
    int         k;
    r    = '0;
    pick = -1;
    case (fn)
      FN_LOOKUP: begin
        for (k = 0; k < N_SLOTS; k++) begin
          if (pick < 0 && slot_valid[k] && slot_ip[k] == ip) begin
            pick        = k;
            r.hit       = 1'b1;
            r.mac       = slot_mac[k];
            r.slot      = k[SLOT_W-1:0];
            slot_age[k] = '0;
          end
        end
      end
      FN_INSERT: begin
        // same IP first (valid or not), then first free slot, then victim
        for (k = 0; k < N_SLOTS; k++)
          if (pick < 0 && slot_ip[k] == ip) pick = k;
        for (k = 0; k < N_SLOTS; k++)
          if (pick < 0 && !slot_valid[k]) pick = k;
        if (pick < 0) begin
          pick       = int'(victim_seq) % N_SLOTS;
          victim_seq = {victim_seq[0] ^ victim_seq[2] ^ victim_seq[3] ^ victim_seq[5],
                        victim_seq[LFSR_W-1:1]};
        end
        slot_ip[pick]    = ip;
        slot_mac[pick]   = mac;
        slot_age[pick]   = '0;
        slot_valid[pick] = 1'b1;
        r.slot           = pick[SLOT_W-1:0];
      end
      FN_TICK: begin
        for (k = 0; k < N_SLOTS; k++) begin
          if (slot_valid[k]) begin
            if (slot_age[k] != AGE_MAX) slot_age[k] = slot_age[k] + 8'd1;
            if (slot_age[k] > age_limit) begin
              slot_valid[k] = 1'b0;
              r.expired     = r.expired + 6'd1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_fault(input string what, input logic [63:0] want_v,
                              input logic [63:0] got_v);
    $display("mismatch @%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
    fault_total++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (idx = 0; idx < N_SLOTS; idx++) begin
        slot_valid[idx] = 1'b0;
        slot_ip[idx]    = '0;
        slot_mac[idx]   = '0;
        slot_age[idx]   = '0;
      end
      victim_seq  = LFSR_SEED;
      age_limit   = TIMEOUT_RST;
      fault_total = 0;
      awaited_replies.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.hit     = out_ch.hit;
        got.mac     = out_ch.mac_out;
        got.slot    = out_ch.slot_index;
        got.expired = out_ch.expired_count;
        if (awaited_replies.size() == 0) begin
          report_fault("result with nothing awaited", 64'd0, 64'(got));
        end else begin
          want = awaited_replies.pop_front();
          if (got.hit !== want.hit)
            report_fault("hit", 64'(want.hit), 64'(got.hit));
          if (got.mac !== want.mac)
            report_fault("mac_out", 64'(want.mac), 64'(got.mac));
          if (got.slot !== want.slot)
            report_fault("slot_index", 64'(want.slot), 64'(got.slot));
          if (got.expired !== want.expired)
            report_fault("expired_count", 64'(want.expired), 64'(got.expired));
        end
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_TIMEOUT)
        age_limit = pwdata[AGE_W-1:0];
      if (in_ch.valid && in_ch.ready)
        awaited_replies.push_back(resolve_arp_item(in_ch.func, in_ch.ip_addr,
                                                   in_ch.mac_addr));
    end
    open_items <= awaited_replies.size();
  end

endmodule

FILE: verif/arp_cache_table_with_aging_test.sv
`timescale 1ns / 100ps

module arp_cache_table_with_aging_test;
  import arp_pkg::*;

  localparam int N_SLOTS        = ENTRIES_DEF;
  localparam int CYCLE_LIMIT    = 400_000;
  localparam int DRAIN_CYCLES   = N_SLOTS + 32;
  localparam int POOL_SIZE      = 40;
  localparam int AGED_COUNT     = N_SLOTS + 4;
  localparam int AGED_HALF      = 30;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 56;
  localparam int HOLDOFF_AFTER  = 120;
  localparam int HOLDOFF_CYCLES = 400;

  localparam logic [AGE_W-1:0] AGED_LIMIT = 8'(2 * AGED_HALF);

  // Function code the block does not define: must leave the table alone.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  arp_in_if  in_ch ();
  arp_out_if out_ch ();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int fault_total;
  int open_items;
  int results_taken = 0;
  int cycle_count   = 0;

  // Sender pacing: items go out in bursts; gap_cap bounds the idle gap after each.
  int burst_left;
  int gap_cap;

  logic [IP_W-1:0]  ip_pool [POOL_SIZE];
  logic [IP_W-1:0]  aged_ip [AGED_COUNT];
  logic [AGE_W-1:0] phase_limit [PHASES] = '{8'd3, 8'd254, 8'd0, 8'd15, 8'd40};
  int               phase_gap   [PHASES] = '{0, 3, 45, 3, 12};

  always #10 clk = ~clk;

  arp_cache_table_with_aging dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  arp_cache_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fault_total (fault_total),
    .open_items  (open_items)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) results_taken <= results_taken + 1;
  end

  // Offer one item at the current falling edge and hold it until the block
  // takes it; then either keep the burst going or drop valid for a gap.
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [IP_W-1:0] ip,
                           input logic [MAC_W-1:0] mac);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.func     <= fn;
    in_ch.ip_addr  <= ip;
    in_ch.mac_addr <= mac;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap        = $urandom_range(0, gap_cap);
      // Lower valid only when a real gap follows, so valid never drops and
      // rises again within one time step.
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Draw a mostly well-formed item: addresses come from a small pool so that
  // lookups hit, inserts reuse slots and the table fills up to eviction.
  task automatic send_random_item();
    int                roll;
    logic [FUNC_W-1:0] fn;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    roll = $urandom_range(0, 99);
    if (roll < 38)      fn = FN_INSERT;
    else if (roll < 78) fn = FN_LOOKUP;
    else if (roll < 95) fn = FN_TICK;
    else                fn = FN_UNUSED;
    if ($urandom_range(0, 4) == 0) ip = $urandom();
    else                           ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    mac = {16'($urandom()), 32'($urandom())};
    if ($urandom_range(0, 15) == 0) mac = '1;
    send_item(fn, ip, mac);
  endtask

  // Drop valid and hold until every item has come back from the block.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (open_items != 0) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle completed at the pready edge.
  task automatic write_timeout(input logic [AGE_W-1:0] limit);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TIMEOUT;
    pwdata  <= {{(CFG_DW - AGE_W){1'b0}}, limit};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: stretches of steady ready, light stalls and heavy stalls,
  // plus one long hold-off that backs the block up into its input.
  initial begin
    int   stretch;
    int   mode;
    logic holdoff_done;
    out_ch.ready = 1'b0;
    stretch      = 0;
    mode         = 0;
    holdoff_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!holdoff_done && results_taken >= HOLDOFF_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_done = 1'b1;
      end
      if (stretch == 0) begin
        mode    = $urandom_range(0, 2);
        stretch = $urandom_range(10, 150);
      end
      stretch--;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    int i;
    int p;
    in_ch.valid    = 1'b0;
    in_ch.func     = FN_LOOKUP;
    in_ch.ip_addr  = '0;
    in_ch.mac_addr = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    burst_left     = 0;
    gap_cap        = 0;

    // Keep the all-zero and all-ones addresses in the pool: zero matches
    // every slot that was never written.
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom();
    for (i = 0; i < AGED_COUNT; i++) aged_ip[i] = {8'h50, 16'($urandom()), 8'(i)};

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, timeout still at its reset value.
    send_item(FN_LOOKUP, 32'h0000_0000, 48'h0);            // empty table: miss on IP 0
    send_item(FN_INSERT, 32'h0000_0000, 48'hFFFF_FFFF_FFFF); // reuses slot 0 holding IP 0
    send_item(FN_LOOKUP, 32'h0000_0000, 48'h0);
    send_item(FN_INSERT, 32'hFFFF_FFFF, 48'h0);
    send_item(FN_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(FN_INSERT, 32'h0A00_0001, 48'h0123_4567_89AB);
    send_item(FN_INSERT, 32'h0A00_0001, 48'hFEDC_BA98_7654); // same IP: overwrite in place
    send_item(FN_LOOKUP, 32'h0A00_0001, 48'h0);
    send_item(FN_UNUSED, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF); // undefined code: no effect
    send_item(FN_TICK, 32'h0, 48'h0);
    send_item(FN_LOOKUP, 32'hC0A8_0001, 48'h0);            // miss on a live table
    wait_drained();

    // Timeout 0: the next tick expires every live entry.
    write_timeout(8'd0);
    send_item(FN_TICK, 32'h0, 48'h0);
    send_item(FN_LOOKUP, 32'h0A00_0001, 48'h0);            // entry now invalid
    send_item(FN_INSERT, 32'hC0A8_0001, 48'h0000_0000_0001);
    send_item(FN_INSERT, 32'h0A00_0001, 48'h8000_0000_0000); // reuse an invalid slot by IP
    send_item(FN_TICK, 32'h0, 48'h0);
    wait_drained();

    // Mid-range timeout: fill past capacity so victims come from the LFSR,
    // refresh a few entries halfway, then age the rest out at the boundary.
    write_timeout(AGED_LIMIT);
    gap_cap = 3;
    for (i = 0; i < AGED_COUNT; i++)
      send_item(FN_INSERT, aged_ip[i], {16'($urandom()), 32'($urandom())});
    for (i = 0; i < AGED_HALF; i++) send_item(FN_TICK, $urandom(), 48'h0);
    for (i = N_SLOTS; i < AGED_COUNT; i++) send_item(FN_LOOKUP, aged_ip[i], 48'h0);
    for (i = 0; i < AGED_HALF + 1; i++) send_item(FN_TICK, $urandom(), 48'h0);
    send_item(FN_LOOKUP, aged_ip[AGED_COUNT - 1], 48'h0);
    wait_drained();

    // Random phases, each with its own timeout and pacing.
    phase_limit[PHASES - 1] = 8'($urandom_range(1, 60));
    for (p = 0; p < PHASES; p++) begin
      write_timeout(phase_limit[p]);
      gap_cap = phase_gap[p];
      for (i = 0; i < PHASE_ITEMS; i++) send_random_item();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fault_total == 0 && open_items == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
